// ===== hdl/mobm_pkg.sv =====
// ----------------------------------------------------------------------------
// mobm_pkg
// shared types, command codes and board variant codes of the outer bank mapper
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mobm_pkg;

  localparam int unsigned BankW = 13;
  localparam int unsigned NumRegs = 8;

  // command codes carried in tuser
  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_PRG   = 2'd1,
    CMD_CHR   = 2'd2
  } cmd_e;

  // board variant codes
  localparam logic [2:0] VAR_ORIG    = 3'd0;
  localparam logic [2:0] VAR_REG1    = 3'd1;
  localparam logic [2:0] VAR_A20     = 3'd2;
  localparam logic [2:0] VAR_DUAL    = 3'd3;
  localparam logic [2:0] VAR_PROTECT = 3'd4;

  // configuration register indexes
  localparam logic [1:0] CFG_BOARD_VARIANT   = 2'd0;
  localparam logic [1:0] CFG_CHR_RAM_PRESENT = 2'd1;
  localparam logic [1:0] CFG_PRG_CHIP_BANKS  = 2'd2;

  // register 2 write merge constants
  localparam logic [7:0] R2_KEEP_MASK = 8'hF1;
  localparam logic [7:0] R2_LOCK_MASK = 8'h0E;

  typedef logic [NumRegs-1:0][7:0] ext_regs_t;

  typedef struct packed {
    logic [2:0]       board_variant;
    logic             chr_ram_present;
    logic [BankW-1:0] prg_chip_banks;
  } cfg_t;

endpackage

`default_nettype wire

// ===== hdl/mobm_ext_regs.sv =====
// ----------------------------------------------------------------------------
// mobm_ext_regs
// eight extension registers with lock and register 2 merge rules
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mobm_ext_regs
  import mobm_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      we_i,
  input  wire logic [2:0] idx_i,
  input  wire logic [7:0] data_i,
  output ext_regs_t      regs_o
);

  ext_regs_t  regs_q;
  ext_regs_t  regs_d;
  logic [7:0] r2;
  logic [7:0] v2;

  assign r2 = regs_q[2];

  always_comb begin
    regs_d = regs_q;
    v2 = data_i;
    if (r2[7]) begin
      v2 = {r2[7:4], data_i[3:0]};
    end
    v2 = v2 & ((({3'b000, ~r2[7:3]}) & R2_LOCK_MASK) | R2_KEEP_MASK);
    if (we_i) begin
      if (idx_i == 3'd2) begin
        regs_d[2] = v2;
      end else if (!regs_q[3][7]) begin
        regs_d[idx_i] = data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q <= '0;
    end else begin
      regs_q <= regs_d;
    end
  end

  assign regs_o = regs_q;

endmodule

`default_nettype wire

// ===== hdl/mobm_prg_xlate.sv =====
// ----------------------------------------------------------------------------
// mobm_prg_xlate
// prg 8k bank translation: outer base and mask over the inner bank
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mobm_prg_xlate
  import mobm_pkg::*;
(
  input  wire ext_regs_t          regs_i,
  input  wire cfg_t               cfg_i,
  input  wire logic [2:0]         addr_hi_i,
  input  wire logic [7:0]         inner_i,
  input  wire logic               inner0_msb_i,
  output logic      [BankW-1:0]   bank_o
);

  logic [7:0]       r0, r1, r3;
  logic [BankW-1:0] base, mask, inner, chip_mask;
  logic             chip;

  assign r0 = regs_i[0];
  assign r1 = regs_i[1];
  assign r3 = regs_i[3];
  assign chip_mask = cfg_i.prg_chip_banks - BankW'(1);

  always_comb begin
    base = '0;
    base[3:1] = r3[3:1];
    base[6:4] = r0[2:0];
    chip = r0[7] ? r0[3] : inner0_msb_i;
    case (cfg_i.board_variant)
      VAR_REG1: begin
        base[7]     = r1[3];
        base[8]     = r1[2];
        base[9]     = r1[1];
        base[11:10] = r0[5:4];
      end
      VAR_A20: begin
        base[8:7] = r0[5:4];
      end
      VAR_DUAL: begin
        base[7]     = r1[4];
        base[9:8]   = r1[3:2];
        base[11:10] = r0[5:4];
        base        = base & chip_mask;
        if (chip) begin
          base = base | cfg_i.prg_chip_banks;
        end
      end
      default: begin
        base[7]     = r1[4];
        base[9:8]   = r1[3:2];
        base[11:10] = r0[5:4];
      end
    endcase

    mask  = {5'b00000, r1[5], r1[6], ~r1[7], ~r0[6], 4'hF};
    inner = {5'b00000, inner_i};
    // gnrom mode: 16k/32k window addressed directly by the cpu
    if (r3[4]) begin
      if (cfg_i.board_variant == VAR_REG1) begin
        mask = r1[4] ? BankW'(1) : BankW'(3);
      end else begin
        mask = r1[1] ? BankW'(3) : BankW'(1);
      end
      inner = {10'b0, addr_hi_i};
    end
    bank_o = (base & ~mask) | (inner & mask);
  end

endmodule

`default_nettype wire

// ===== hdl/mobm_chr_xlate.sv =====
// ----------------------------------------------------------------------------
// mobm_chr_xlate
// chr 1k bank translation, chr-ram select and write enable
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mobm_chr_xlate
  import mobm_pkg::*;
(
  input  wire ext_regs_t        regs_i,
  input  wire cfg_t             cfg_i,
  input  wire logic [5:0]       addr_hi_i,
  input  wire logic [7:0]       inner_i,
  output logic      [BankW-1:0] bank_o,
  output logic                  ram_sel_o,
  output logic                  writable_o
);

  logic [7:0]       r0, r2, r3, r4;
  logic [BankW-1:0] base, mask, inner;

  assign r0 = regs_i[0];
  assign r2 = regs_i[2];
  assign r3 = regs_i[3];
  assign r4 = regs_i[4];

  assign ram_sel_o  = cfg_i.chr_ram_present && r4[0] && (inner_i[7:1] == r4[7:1]);
  assign writable_o = !((cfg_i.board_variant == VAR_PROTECT) && r0[4] && !ram_sel_o);

  always_comb begin
    base = {3'b000, r0[5:3], r2[3:0], 3'b000};
    mask = r0[7] ? BankW'(8'h7F) : BankW'(8'hFF);
    inner = {5'b00000, inner_i};
    if (r3[4]) begin
      mask  = BankW'(3'h7);
      inner = {7'b0, addr_hi_i};
    end
    bank_o = (base & ~mask) | (inner & mask);
  end

endmodule

`default_nettype wire

// ===== hdl/multicart_outer_bank_mapper.sv =====
// throughput: one beat per cycle while the sink accepts results, set by the input and result registers
// a register write takes effect for the very next beat
// reset: rst_ni async active low clears valid flags, extension registers
// and configuration (variant 0, no chr-ram, 256 banks per prg chip)
// ----------------------------------------------------------------------------
// multicart_outer_bank_mapper
// outer bank logic of a multicart over an inner mapper: extension register
// writes, prg and chr bank translation, one result beat per input beat
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module multicart_outer_bank_mapper
  import mobm_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration write port
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [12:0] cfg_data_i,
  // input stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // fields from bit 0: address[15:0], value[23:16], inner_chr_reg0[31:24]
  input  wire logic [31:0] s_axis_tdata,
  // fields from bit 0: command[1:0]
  input  wire logic [1:0]  s_axis_tuser,
  // result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // fields from bit 0: bank[12:0], chr_ram_select[13], chr_writable[14], zero[15]
  output logic [15:0]      m_axis_tdata
);

  // configuration registers
  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.board_variant   <= VAR_ORIG;
      cfg_q.chr_ram_present <= 1'b0;
      cfg_q.prg_chip_banks  <= BankW'(256);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_BOARD_VARIANT:   cfg_q.board_variant   <= cfg_data_i[2:0];
        CFG_CHR_RAM_PRESENT: cfg_q.chr_ram_present <= cfg_data_i[0];
        CFG_PRG_CHIP_BANKS:  cfg_q.prg_chip_banks  <= cfg_data_i;
        default: ;  // index outside the list is ignored
      endcase
    end
  end

  // input register stage
  logic        s1_valid_q;
  logic [1:0]  s1_cmd_q;
  logic [15:0] s1_addr_q;
  logic [7:0]  s1_value_q;
  logic [7:0]  s1_inner0_q;

  // result register stage
  logic             out_valid_q;
  logic [BankW-1:0] out_bank_q, out_bank_d;
  logic             out_ram_q, out_ram_d;
  logic             out_wr_q, out_wr_d;

  logic advance;   // input stage moves into the result register
  logic s_accept;

  assign advance       = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || advance;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      s1_cmd_q    <= s_axis_tuser;
      s1_addr_q   <= s_axis_tdata[15:0];
      s1_value_q  <= s_axis_tdata[23:16];
      s1_inner0_q <= s_axis_tdata[31:24];
    end
  end

  // extension registers, written as the write beat leaves the input stage
  ext_regs_t regs;

  mobm_ext_regs u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (advance && (s1_cmd_q == CMD_WRITE)),
    .idx_i  (s1_addr_q[2:0]),
    .data_i (s1_value_q),
    .regs_o (regs)
  );

  // translation units
  logic [BankW-1:0] prg_bank, chr_bank;
  logic             chr_ram, chr_wr;

  mobm_prg_xlate u_prg (
    .regs_i       (regs),
    .cfg_i        (cfg_q),
    .addr_hi_i    (s1_addr_q[15:13]),
    .inner_i      (s1_value_q),
    .inner0_msb_i (s1_inner0_q[7]),
    .bank_o       (prg_bank)
  );

  mobm_chr_xlate u_chr (
    .regs_i     (regs),
    .cfg_i      (cfg_q),
    .addr_hi_i  (s1_addr_q[15:10]),
    .inner_i    (s1_value_q),
    .bank_o     (chr_bank),
    .ram_sel_o  (chr_ram),
    .writable_o (chr_wr)
  );

  // result select by command; writes and the unused code give all zero
  always_comb begin
    out_bank_d = '0;
    out_ram_d  = 1'b0;
    out_wr_d   = 1'b0;
    unique case (s1_cmd_q)
      CMD_PRG: begin
        out_bank_d = prg_bank;
      end
      CMD_CHR: begin
        out_bank_d = chr_bank;
        out_ram_d  = chr_ram;
        out_wr_d   = chr_wr;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_bank_q <= out_bank_d;
      out_ram_q  <= out_ram_d;
      out_wr_q   <= out_wr_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_wr_q, out_ram_q, out_bank_q};

`ifndef SYNTHESIS
  // input side stalls only when both stages are full and the sink holds off
  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (s1_valid_q && out_valid_q && !m_axis_tready))
    else $error("input stalled without a full pipeline");

  // a beat leaving the input stage always shows up as a result
  a_advance_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("advanced beat lost");

  // register writes produce an all zero result
  a_write_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && (s1_cmd_q == CMD_WRITE)) |=> (m_axis_tdata == 16'h0000))
    else $error("write beat gave a nonzero result");
`endif

endmodule

`default_nettype wire
